[sv/ipxs_pkg.sv]
// Shared types and constants for the integer pixel replication scaler.
`timescale 1ns / 1ps

package ipxs_pkg;

    localparam int PIX_W        = 24;
    localparam int SCALE_REG_W  = 7;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int USER_OUT_W   = 5;

    // job queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // input opcodes (carried on tuser)
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_HEIGHT = 2'd2;

    typedef struct packed {
        logic [SCALE_REG_W-1:0]  scale;
        logic [WIDTH_REG_W-1:0]  in_width;
        logic [HEIGHT_REG_W-1:0] in_height;
    } t_cfg;

    // one classified item: a pixel to be sent reps times
    typedef struct packed {
        logic [PIX_W-1:0]       pix;
        logic [SCALE_REG_W-1:0] reps;
        logic                   row_end;
        logic [1:0]             pad;
        logic                   frame_end;
        logic                   rejected;
    } t_job;

endpackage

[sv/ipxs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ipxs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/ipxs_front.sv]
// Front end: accepts beats, tracks row/pass/frame position, owns the line buffer.
`timescale 1ns / 1ps

module ipxs_front #(
    parameter int MAX_SCALE = 64,
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ipxs_pkg::t_cfg                i_cfg,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_opcode,
    input  logic [ipxs_pkg::PIX_W-1:0]    i_pixel,
    input  logic [ipxs_pkg::Q_CNT_W-1:0]  i_q_count,
    output logic                          o_push,
    output ipxs_pkg::t_job                o_job
);
    import ipxs_pkg::*;

    localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int PW   = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int WCW  = (WW > WIDTH_REG_W) ? WW : WIDTH_REG_W;
    localparam int SCW  = SCALE_REG_W + 1;
    localparam int HCW  = HEIGHT_REG_W + 1;

    // position state
    logic [CW-1:0]           r_col, n_col;
    logic [PW-1:0]           r_pass, n_pass;
    logic [HEIGHT_REG_W-1:0] r_row, n_row;
    logic                    r_replaying, n_replaying;

    // stage holding an accepted item while the buffer read completes
    logic   r_s1_vld;
    logic   r_s1_use_ram;
    t_job   r_s1_job;
    t_job   n_s1_job;

    logic [SCALE_REG_W-1:0]  eff_s;
    logic [WCW-1:0]          eff_w;
    logic [HEIGHT_REG_W-1:0] eff_h;
    logic                    fire;
    logic                    rej;
    logic                    row_done;
    logic                    pass_final;
    logic                    frame_done;
    logic [3:0]              wsl;
    logic [1:0]              pad;
    logic                    ram_we;
    logic                    ram_re;
    logic [PIX_W-1:0]        ram_rdata;

    // effective register values
    always_comb begin
        if (i_cfg.scale == '0) begin
            eff_s = SCALE_REG_W'(1);
        end else if (i_cfg.scale > SCALE_REG_W'(MAX_SCALE)) begin
            eff_s = SCALE_REG_W'(MAX_SCALE);
        end else begin
            eff_s = i_cfg.scale;
        end
        if (i_cfg.in_width == '0) begin
            eff_w = WCW'(1);
        end else if (WCW'(i_cfg.in_width) > WCW'(MAX_WIDTH)) begin
            eff_w = WCW'(MAX_WIDTH);
        end else begin
            eff_w = WCW'(i_cfg.in_width);
        end
        eff_h = (i_cfg.in_height == '0) ? HEIGHT_REG_W'(1) : i_cfg.in_height;
    end

    // queue slots must cover the item already in flight
    assign o_ready = ((Q_CNT_W + 1)'(i_q_count) + (Q_CNT_W + 1)'(r_s1_vld))
                     < (Q_CNT_W + 1)'(Q_DEPTH);
    assign fire    = i_valid && o_ready;
    assign rej     = (i_opcode == OP_PUSH) ? r_replaying : !r_replaying;

    // row / pass / frame decisions
    assign row_done   = ((WCW + 1)'(r_col) + (WCW + 1)'(1)) >= (WCW + 1)'(eff_w);
    assign pass_final = r_replaying ? ((SCW'(r_pass) + SCW'(1)) >= SCW'(eff_s))
                                    : (eff_s <= SCALE_REG_W'(1));
    assign frame_done = pass_final && ((HCW'(r_row) + HCW'(1)) >= HCW'(eff_h));

    // pad = -(3 * w * s) mod 4, only the low two bits matter
    assign wsl = 4'(eff_w[1:0]) * 4'(eff_s[1:0]);
    assign pad = 2'd0 - 2'(wsl * 4'd3);

    // next position state and the job for this item
    always_comb begin
        n_col       = r_col;
        n_pass      = r_pass;
        n_row       = r_row;
        n_replaying = r_replaying;
        n_s1_job    = '0;
        n_s1_job.reps = SCALE_REG_W'(1);
        if (rej) begin
            n_s1_job.rejected = 1'b1;
        end else begin
            n_s1_job.pix       = i_pixel;
            n_s1_job.reps      = eff_s;
            n_s1_job.row_end   = row_done;
            n_s1_job.pad       = row_done ? pad : 2'd0;
            n_s1_job.frame_end = row_done && frame_done;
            if (!row_done) begin
                n_col = r_col + CW'(1);
            end else begin
                n_col = '0;
                if (pass_final) begin
                    n_replaying = 1'b0;
                    n_pass      = '0;
                    n_row       = frame_done ? '0 : r_row + HEIGHT_REG_W'(1);
                end else if (!r_replaying) begin
                    n_replaying = 1'b1;
                    n_pass      = PW'(1);
                end else begin
                    n_pass = r_pass + PW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_pass      <= '0;
            r_row       <= '0;
            r_replaying <= 1'b0;
            r_s1_vld    <= 1'b0;
        end else begin
            r_s1_vld <= fire;
            if (fire) begin
                r_col       <= n_col;
                r_pass      <= n_pass;
                r_row       <= n_row;
                r_replaying <= n_replaying;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_s1_job     <= n_s1_job;
            r_s1_use_ram <= !rej && (i_opcode == OP_TICK);
        end
    end

    // line buffer: pushes write the column, ticks read it back
    assign ram_we = fire && !rej && (i_opcode == OP_PUSH);
    assign ram_re = fire && !rej && (i_opcode == OP_TICK);

    ipxs_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_col),
        .i_wdata (i_pixel),
        .i_re    (ram_re),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        o_job = r_s1_job;
        if (r_s1_use_ram) begin
            o_job.pix = ram_rdata;
        end
    end
    assign o_push = r_s1_vld;

endmodule

[sv/ipxs_queue.sv]
// Short job queue decoupling the front end from the output expander.
`timescale 1ns / 1ps

module ipxs_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  ipxs_pkg::t_job                i_job,
    input  logic                          i_pop,
    output ipxs_pkg::t_job                o_head,
    output logic                          o_head_vld,
    output logic [ipxs_pkg::Q_CNT_W-1:0]  o_count
);
    import ipxs_pkg::*;

    t_job               r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count, n_count;
    logic               do_pop;

    assign do_pop = i_pop && (r_count != '0);

    always_comb begin
        n_count = r_count;
        if (i_push && !do_pop) begin
            n_count = r_count + Q_CNT_W'(1);
        end else if (!i_push && do_pop) begin
            n_count = r_count - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    assign o_head     = r_slot[r_rd_ptr];
    assign o_head_vld = (r_count != '0);
    assign o_count    = r_count;

endmodule

[sv/ipxs_back.sv]
// Back end: expands each job into its run of output beats through an output register.
`timescale 1ns / 1ps

module ipxs_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ipxs_pkg::t_job                   i_head,
    input  logic                             i_head_vld,
    output logic                             o_pop,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [ipxs_pkg::PIX_W-1:0]       o_pixel,
    output logic [ipxs_pkg::USER_OUT_W-1:0]  o_user,
    output logic                             o_last
);
    import ipxs_pkg::*;

    logic [SCALE_REG_W-1:0] r_k;
    logic                   r_vld;
    logic [PIX_W-1:0]       r_pixel;
    logic [USER_OUT_W-1:0]  r_user;
    logic                   r_last;
    logic                   load;
    logic                   last_rep;

    // output register takes a new beat when empty or being drained
    assign load     = i_head_vld && (!r_vld || i_ready);
    assign last_rep = (r_k + SCALE_REG_W'(1)) >= i_head.reps;
    assign o_pop    = load && last_rep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k   <= '0;
            r_vld <= 1'b0;
        end else begin
            if (load) begin
                r_vld <= 1'b1;
                r_k   <= last_rep ? '0 : r_k + SCALE_REG_W'(1);
            end else if (i_ready) begin
                r_vld <= 1'b0;
            end
        end
    end

    // run flags only on the final beat of the run
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_pixel <= i_head.pix;
            r_last  <= last_rep;
            r_user  <= {i_head.rejected,
                        i_head.frame_end && last_rep,
                        last_rep ? i_head.pad : 2'd0,
                        i_head.row_end && last_rep};
        end
    end

    assign o_valid = r_vld;
    assign o_pixel = r_pixel;
    assign o_user  = r_user;
    assign o_last  = r_last;

endmodule

[sv/integer_pixel_replication_scaler_top.sv]
// Top level of the integer pixel replication scaler.
`timescale 1ns / 1ps
//
// Whole-factor nearest-neighbor upscaler for a 24-bit pixel stream.
// Slave side: tdata carries a pixel, tuser the opcode (push pixel or replay tick).
// Each pushed pixel is stored in a line buffer and sent out scale times; once a
// row is in and scale is above one, each tick replays the next stored pixel
// scale times until the row has gone out scale times. Items in the wrong phase
// give a single beat flagged rejected.
// Master side: one beat per cycle while a job waits and tready is high; tlast marks
// the last beat of each item's run. A run's first beat passes the front-end stage
// register, the job queue and the output register. Throughput: an item occupies
// the output for scale beats (one when rejected), one a cycle while tready is high.
// With scale 1 a new item is taken every cycle while the receiver keeps up.
// A 4-entry job queue separates intake from output, so intake keeps going while
// the receiver stalls until the queue fills; then tready drops.
// Reset (synchronous, active low) returns to ingest phase at column, pass and
// row zero, and sets all three configuration registers to 1. Line buffer
// contents are not cleared. Configure while idle through the write port.
//
module integer_pixel_replication_scaler_top #(
    parameter int MAX_SCALE = 64,
    parameter int MAX_WIDTH = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // config write port
    input  logic                               i_cfg_we,
    input  logic [ipxs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ipxs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input stream
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [23:0]                        i_s_axis_tdata,   // [23:0] pixel_in
    input  logic                               i_s_axis_tuser,   // [0] opcode
    // output stream
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [23:0]                        o_m_axis_tdata,   // [23:0] pixel_out
    // [0] row_end, [2:1] pad_bytes, [3] frame_end, [4] rejected
    output logic [ipxs_pkg::USER_OUT_W-1:0]    o_m_axis_tuser,
    output logic                               o_m_axis_tlast    // run_last
);
    import ipxs_pkg::*;

    t_cfg               r_cfg;
    logic               push;
    t_job               job;
    t_job               head;
    logic               head_vld;
    logic               pop;
    logic [Q_CNT_W-1:0] q_count;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scale     <= SCALE_REG_W'(1);
            r_cfg.in_width  <= WIDTH_REG_W'(1);
            r_cfg.in_height <= HEIGHT_REG_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SCALE:     r_cfg.scale     <= i_cfg_data[SCALE_REG_W-1:0];
                CFG_IN_WIDTH:  r_cfg.in_width  <= i_cfg_data[WIDTH_REG_W-1:0];
                CFG_IN_HEIGHT: r_cfg.in_height <= i_cfg_data[HEIGHT_REG_W-1:0];
                default: ;
            endcase
        end
    end

    ipxs_front #(
        .MAX_SCALE (MAX_SCALE),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_opcode  (i_s_axis_tuser),
        .i_pixel   (i_s_axis_tdata),
        .i_q_count (q_count),
        .o_push    (push),
        .o_job     (job)
    );

    ipxs_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_job      (job),
        .i_pop      (pop),
        .o_head     (head),
        .o_head_vld (head_vld),
        .o_count    (q_count)
    );

    ipxs_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_head_vld (head_vld),
        .o_pop      (pop),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_pixel    (o_m_axis_tdata),
        .o_user     (o_m_axis_tuser),
        .o_last     (o_m_axis_tlast)
    );

endmodule

[sv/ipxs_checker.sv]
// Port-level checks for the scaler output stream, bound to the top level.
`timescale 1ns / 1ps

module ipxs_props (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_m_axis_tvalid,
    input logic                              i_m_axis_tready,
    input logic [23:0]                       o_m_axis_tdata,
    input logic [ipxs_pkg::USER_OUT_W-1:0]   o_m_axis_tuser,
    input logic                              o_m_axis_tlast
);

    // a rejected beat stands alone and carries nothing else
    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[4]) |->
            (o_m_axis_tlast && (o_m_axis_tdata == 24'd0) && (o_m_axis_tuser[3:0] == 4'd0)))
        else $error("rejected beat carries data or flags");

    // row end only on the final beat of a run
    a_row_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> o_m_axis_tlast)
        else $error("row end away from run end");

    // frame end implies row end
    a_frame_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[3]) |-> o_m_axis_tuser[0])
        else $error("frame end without row end");

    // padding is only reported with row end
    a_pad_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser[2:1] != 2'd0)) |-> o_m_axis_tuser[0])
        else $error("pad bytes without row end");

    // stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
             && $stable(o_m_axis_tlast)))
        else $error("stalled output beat changed");

endmodule

bind integer_pixel_replication_scaler_top ipxs_props u_ipxs_checker (.*);
